// ----- rtl/core/script_lexer_byte_stream_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the script lexer.
// Each macro checks a property on the rising edge of clk, with the check
// switched off while rst_n is low. Under SYNTHESIS the macros are empty.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LEXER_BYTE_STREAM_ASSERT_SVH
`define SCRIPT_LEXER_BYTE_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SLB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define SLB_ASSERT_IMPLY(label, ante, cons)
`define SLB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/slbs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slbs_pkg
// Types, token codes, the keyword table and the character classes for the
// script lexer.
// ----------------------------------------------------------------------------
package slbs_pkg;

    localparam int OFFSET_BITS   = 16;
    localparam int LINE_BITS     = 16;
    localparam int KEYWORD_CHARS = 6;
    localparam int KEYWORD_COUNT = 22;

    // Token codes.
    localparam logic [5:0] K_DOT     = 6'd7;
    localparam logic [5:0] K_SLASH   = 6'd11;
    localparam logic [5:0] K_BANG    = 6'd15;
    localparam logic [5:0] K_EQUAL   = 6'd17;
    localparam logic [5:0] K_GREATER = 6'd19;
    localparam logic [5:0] K_LESS    = 6'd21;
    localparam logic [5:0] K_STRING  = 6'd23;
    localparam logic [5:0] K_NUMBER  = 6'd24;
    localparam logic [5:0] K_KW_BASE = 6'd25;
    localparam logic [5:0] K_IDENT   = 6'd47;
    localparam logic [5:0] K_ERROR   = 6'd48;
    localparam logic [5:0] K_EOF     = 6'd49;

    // Error codes.
    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM_STR = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } tok_item_t;

    // Keywords, first character in the top byte, padded with spaces.
    localparam logic [8*KEYWORD_CHARS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        "and   ", "async ", "await ", "class ", "else  ", "false ",
        "finish", "for   ", "fun   ", "future", "if    ", "lambda",
        "nil   ", "or    ", "print ", "reduce", "return", "super ",
        "this  ", "true  ", "var   ", "while "
    };
    localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
        3'd3, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd6, 3'd3, 3'd3, 3'd6, 3'd2,
        3'd6, 3'd3, 3'd2, 3'd5, 3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // Keyword code for an identifier of at most six characters.
    function automatic logic [5:0] kw_lookup(input logic [8*KEYWORD_CHARS-1:0] text,
                                             input logic [2:0] len);
        logic [5:0] kind;
        logic       hit;
        kind = K_IDENT;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
            hit = (KW_LEN[i] == len);
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if ((j < int'(len)) && (text[8*(KEYWORD_CHARS-j)-1 -: 8]
                                         != KW_TEXT[i][8*(KEYWORD_CHARS-j)-1 -: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = K_KW_BASE + 6'(i);
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] op, input logic doubled);
        logic [5:0] base;
        case (op)
            "!":     base = K_BANG;
            "=":     base = K_EQUAL;
            ">":     base = K_GREATER;
            default: base = K_LESS;
        endcase
        return doubled ? base + 6'd1 : base;
    endfunction

    // Returns a hit flag and the code of a single-character token.
    function automatic logic [6:0] single_kind(input logic [7:0] c);
        case (c)
            "(":     return {1'b1, 6'd0};
            ")":     return {1'b1, 6'd1};
            "{":     return {1'b1, 6'd2};
            "}":     return {1'b1, 6'd3};
            "[":     return {1'b1, 6'd4};
            "]":     return {1'b1, 6'd5};
            ",":     return {1'b1, 6'd6};
            ".":     return {1'b1, 6'd7};
            "-":     return {1'b1, 6'd8};
            "+":     return {1'b1, 6'd9};
            ";":     return {1'b1, 6'd10};
            "/":     return {1'b1, 6'd11};
            "*":     return {1'b1, 6'd12};
            ":":     return {1'b1, 6'd13};
            "%":     return {1'b1, 6'd14};
            default: return {1'b0, 6'd0};
        endcase
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] low16(input logic [31:0] v);
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/script_lexer_byte_stream.sv -----
`default_nettype none
// Latency: an item's first token is queued in the cycle after the item is taken.
// Throughput: one byte per cycle while the source is not stalled; each byte yields zero to three tokens.
// Tokens drain one per cycle while tok_stall is low, from an eight-entry queue; the source stalls while
// fewer than three queue entries are free.
// Reset clears the lexer state and empties the queue; line count restarts at one.
// ----------------------------------------------------------------------------
// script_lexer_byte_stream
// Streaming lexer: source bytes in, tokens with kind, offset, length and line out.
// ----------------------------------------------------------------------------
module script_lexer_byte_stream
    import slbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire src_item_t src_item,
    output logic           tok_valid,
    input  wire logic      tok_stall,
    output tok_item_t      tok_item
);

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int MAX_BURST  = 3;
    localparam logic [OFFSET_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_CAP = '1;

    // The lexer mode. A token that needs to see the next byte waits in one
    // of these modes and is emitted when that byte, or end of source, arrives.
    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_SLASH, M_OP, M_INT, M_DOT, M_FRAC, M_IDENT, M_STRING
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic [7:0]             prefix_reg [KEYWORD_CHARS];

    logic                   pre_we;
    logic [2:0]             pre_idx;

    tok_item_t              em [MAX_BURST];
    logic [1:0]             n_push;

    tok_item_t              fifo_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]      count_reg;

    logic                   take;
    logic                   pop;
    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] grown;
    logic [8*KEYWORD_CHARS-1:0] prefix_flat;
    logic [5:0]             ident_code;

    // The queue must always have room for the longest burst of one item.
    assign src_stall = count_reg > (PTR_BITS + 1)'(FIFO_DEPTH - MAX_BURST);
    assign take      = src_valid && !src_stall;
    assign tok_valid = count_reg != '0;
    assign tok_item  = fifo_reg[rd_ptr_reg];
    assign pop       = tok_valid && !tok_stall;
    assign c         = src_item.char_byte;
    assign grown     = (len_reg == LEN_MAX) ? len_reg : len_reg + OFFSET_BITS'(1);

    always_comb
    begin
        for (int j = 0; j < KEYWORD_CHARS; j++)
        begin
            prefix_flat[8*(KEYWORD_CHARS-j)-1 -: 8] = prefix_reg[j];
        end
    end

    // An identifier longer than the keyword prefix is never a keyword.
    assign ident_code = (len_reg > OFFSET_BITS'(KEYWORD_CHARS)) ? K_IDENT
                      : kw_lookup(prefix_flat, len_reg[2:0]);

    function automatic tok_item_t mk(input logic [5:0] kind, input logic [1:0] err,
                                     input logic [OFFSET_BITS-1:0] st,
                                     input logic [OFFSET_BITS-1:0] ln,
                                     input logic [LINE_BITS-1:0] lc);
        tok_item_t t;
        t.token_kind   = kind;
        t.error_kind   = err;
        t.token_start  = low16(32'(st));
        t.token_length = sat16(32'(ln));
        t.line_number  = sat16(32'(lc));
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // One pass over the accepted item: the pending token is closed first, and
    // then the byte itself is handled as if the lexer were idle.
    always_comb
    begin
        logic       fall;
        logic [6:0] sk;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        off_next   = off_reg + OFFSET_BITS'(1);
        line_next  = line_reg;
        len_next   = len_reg;
        pre_we     = 1'b0;
        pre_idx    = '0;
        n_push     = '0;
        fall       = 1'b0;
        sk         = single_kind(c);
        for (int i = 0; i < MAX_BURST; i++)
        begin
            em[i] = '0;
        end

        if (src_item.end_of_source)
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    em[n_push] = mk(K_SLASH, E_NONE, start_reg, OFFSET_BITS'(1), line_reg);
                    n_push = n_push + 2'd1;
                end
                M_OP:
                begin
                    em[n_push] = mk(op_kind(pend_reg, 1'b0), E_NONE, start_reg,
                                    OFFSET_BITS'(1), line_reg);
                    n_push = n_push + 2'd1;
                end
                M_INT, M_FRAC:
                begin
                    em[n_push] = mk(K_NUMBER, E_NONE, start_reg, len_reg, line_reg);
                    n_push = n_push + 2'd1;
                end
                M_DOT:
                begin
                    em[n_push] = mk(K_NUMBER, E_NONE, start_reg,
                                    (len_reg < LEN_MAX) ? len_reg - OFFSET_BITS'(1) : len_reg,
                                    line_reg);
                    n_push = n_push + 2'd1;
                    em[n_push] = mk(K_DOT, E_NONE, off_reg - OFFSET_BITS'(1),
                                    OFFSET_BITS'(1), line_reg);
                    n_push = n_push + 2'd1;
                end
                M_IDENT:
                begin
                    em[n_push] = mk(ident_code, E_NONE, start_reg, len_reg, line_reg);
                    n_push = n_push + 2'd1;
                end
                M_STRING:
                begin
                    em[n_push] = mk(K_ERROR, E_UNTERM_STR, start_reg, '0, line_reg);
                    n_push = n_push + 2'd1;
                end
                default:
                begin
                end
            endcase
            em[n_push] = mk(K_EOF, E_NONE, off_reg, '0, line_reg);
            n_push = n_push + 2'd1;
            mode_next  = M_IDLE;
            pend_next  = '0;
            start_next = '0;
            off_next   = '0;
            line_next  = LINE_BITS'(1);
            len_next   = '0;
        end
        else
        begin
            case (mode_reg)
                M_COMMENT:
                begin
                    fall = (c == "\n");
                end
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        em[n_push] = mk(K_SLASH, E_NONE, start_reg, OFFSET_BITS'(1), line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_OP:
                begin
                    if (c == "=")
                    begin
                        em[n_push] = mk(op_kind(pend_reg, 1'b1), E_NONE, start_reg,
                                        OFFSET_BITS'(2), line_reg);
                        n_push = n_push + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        em[n_push] = mk(op_kind(pend_reg, 1'b0), E_NONE, start_reg,
                                        OFFSET_BITS'(1), line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(c))
                    begin
                        len_next = grown;
                    end
                    else if (c == ".")
                    begin
                        len_next  = grown;
                        mode_next = M_DOT;
                    end
                    else
                    begin
                        em[n_push] = mk(K_NUMBER, E_NONE, start_reg, len_reg, line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(c))
                    begin
                        len_next  = grown;
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        // A trailing dot is not part of the number.
                        em[n_push] = mk(K_NUMBER, E_NONE, start_reg,
                                        (len_reg < LEN_MAX) ? len_reg - OFFSET_BITS'(1)
                                                            : len_reg, line_reg);
                        n_push = n_push + 2'd1;
                        em[n_push] = mk(K_DOT, E_NONE, off_reg - OFFSET_BITS'(1),
                                        OFFSET_BITS'(1), line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        len_next = grown;
                    end
                    else
                    begin
                        em[n_push] = mk(K_NUMBER, E_NONE, start_reg, len_reg, line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (len_reg < OFFSET_BITS'(KEYWORD_CHARS))
                        begin
                            pre_we  = 1'b1;
                            pre_idx = len_reg[2:0];
                        end
                        len_next = grown;
                    end
                    else
                    begin
                        em[n_push] = mk(ident_code, E_NONE, start_reg, len_reg, line_reg);
                        n_push = n_push + 2'd1;
                        fall = 1'b1;
                    end
                end
                M_STRING:
                begin
                    len_next = grown;
                    if (c == "\"")
                    begin
                        em[n_push] = mk(K_STRING, E_NONE, start_reg, grown, line_reg);
                        n_push = n_push + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if ((c == "\n") && (line_reg < LINE_CAP))
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            if (fall)
            begin
                mode_next = M_IDLE;
                if ((c == " ") || (c == "\r") || (c == "\t"))
                begin
                end
                else if (c == "\n")
                begin
                    if (line_reg < LINE_CAP)
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end
                else if (c == "/" || is_digit(c) || is_alpha(c) || c == "\"" ||
                         c == "!" || c == "=" || c == "<" || c == ">")
                begin
                    start_next = off_reg;
                    len_next   = OFFSET_BITS'(1);
                    if (c == "/")
                    begin
                        mode_next = M_SLASH;
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = M_INT;
                    end
                    else if (is_alpha(c))
                    begin
                        mode_next = M_IDENT;
                        pre_we    = 1'b1;
                        pre_idx   = '0;
                    end
                    else if (c == "\"")
                    begin
                        mode_next = M_STRING;
                    end
                    else
                    begin
                        mode_next = M_OP;
                        pend_next = c;
                    end
                end
                else if (sk[6])
                begin
                    em[n_push] = mk(sk[5:0], E_NONE, off_reg, OFFSET_BITS'(1), line_reg);
                    n_push = n_push + 2'd1;
                end
                else
                begin
                    em[n_push] = mk(K_ERROR, E_UNEXPECTED, off_reg, '0, line_reg);
                    n_push = n_push + 2'd1;
                end
            end
        end

        if (n_push != '0)
        begin
            em[n_push - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pend_reg   <= '0;
            start_reg  <= '0;
            off_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                start_reg  <= start_next;
                off_reg    <= off_next;
                line_reg   <= line_next;
                len_reg    <= len_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(n_push);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg + (take ? (PTR_BITS + 1)'(n_push) : '0)
                                   - (pop ? (PTR_BITS + 1)'(1) : '0);
        end
    end

    // Identifier prefix and queue payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (take && pre_we)
        begin
            prefix_reg[pre_idx] <= c;
        end
        for (int i = 0; i < MAX_BURST; i++)
        begin
            if (take && (i < int'(n_push)))
            begin
                fifo_reg[wr_ptr_reg + PTR_BITS'(i)] <= em[i];
            end
        end
    end

    `include "script_lexer_byte_stream_assert.svh"

    `SLB_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= (PTR_BITS + 1)'(FIFO_DEPTH))
    `SLB_ASSERT_NEXT(a_eof_restart, take && src_item.end_of_source,
                     (off_reg == '0) && (mode_reg == M_IDLE) && (line_reg == LINE_BITS'(1)))
    `SLB_ASSERT_NEXT(a_eof_queued, take && src_item.end_of_source && !pop,
                     count_reg > $past(count_reg))
    `SLB_ASSERT_IMPLY(a_line_nonzero, 1'b1, line_reg != '0)

endmodule
`default_nettype wire
